// File: design/mccps_pkg.sv
// Package for the MIDI CC profile selector.
// Holds widths, codes, the sequencer state type and small helper functions.
// No dependencies.
package mccps_pkg;

    localparam int MAX_PROFILES = 32;
    localparam int PROF_W       = 6;
    localparam int IDX_W        = 5;
    localparam int NUM_W        = 12;
    localparam int DIV_STEPS    = NUM_W;
    localparam int STEP_W       = 4;

    localparam logic [7:0] CC_STATUS_BASE = 8'hB0;
    localparam logic [6:0] CC_VALUE_MAX   = 7'd127;

    localparam logic [5:0] RST_PROFILE_COUNT = 6'd2;
    localparam logic [5:0] RST_HOME_PROFILE  = 6'd1;
    localparam logic [4:0] RST_MIDI_CHANNEL  = 5'd1;
    localparam logic [6:0] RST_CC_NUMBER     = 7'd119;
    localparam logic [5:0] RST_CUR_PROFILE   = 6'd1;

    typedef enum logic [1:0] {
        OP_MIDI_IN = 2'd0,
        OP_STEP    = 2'd1,
        OP_HOME    = 2'd2,
        OP_RESEND  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_PROFILE_COUNT = 2'd0,
        REG_HOME_PROFILE  = 2'd1,
        REG_MIDI_CHANNEL  = 2'd2,
        REG_CC_NUMBER     = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] lo,
                                          input logic [5:0] hi);
        logic [5:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // Dividend for the CC value of profile index idx: 128*idx + den/2.
    function automatic logic [NUM_W-1:0] cc_dividend(input logic [IDX_W-1:0] idx,
                                                     input logic [IDX_W-1:0] den);
        return {idx, 7'b0} + {8'b0, den[IDX_W-1:1]};
    endfunction

endpackage

// File: design/midi_cc_profile_selector.sv
// Top level of the MIDI CC profile selector: config registers, sequencer and
// a shared shift-subtract divider. Depends on mccps_pkg.
//
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// input     | in        | i_in_valid / o_in_ready    | op, status_in, data1_in, data2_in,
//           |           |                            | step_up
// result    | out       | o_out_valid / i_out_ready  | send_valid, status_out, cc_out,
//           |           |                            | value_out, profile_out
// config    | in        | APB psel/penable/pwrite    | four registers at 0x0, 0x4, 0x8, 0xC
//
// An item that sends a CC with more than one profile has its result ready once
// the one-bit-per-cycle divider has produced every quotient bit and the
// evaluation state has run. A matching incoming CC runs the divider and the
// evaluation state once per profile. Other items go straight to the result.
// The divider is the single shared unit; only one item is in flight at a time.
// Reset returns the sequencer, the selected profile and the config registers
// to their reset values. A result waits in the output register until it is
// taken; no new item is accepted meanwhile.
module midi_cc_profile_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_status_in,
    input  logic [7:0]  i_data1_in,
    input  logic [7:0]  i_data2_in,
    input  logic        i_step_up,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_valid,
    output logic [7:0]  o_status_out,
    output logic [6:0]  o_cc_out,
    output logic [6:0]  o_value_out,
    output logic [5:0]  o_profile_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [5:0] r_profile_count;
    logic [5:0] r_home_profile;
    logic [4:0] r_midi_channel;
    logic [6:0] r_cc_number;

    // Sequencer and datapath registers.
    mccps_pkg::t_state r_state, n_state;
    logic [5:0]                        r_profile, n_profile;
    logic                              r_search, n_search;
    logic [mccps_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [mccps_pkg::IDX_W-1:0]       r_best, n_best;
    logic [7:0]                        r_bestd, n_bestd;
    logic [6:0]                        r_val, n_val;
    logic [mccps_pkg::IDX_W-1:0]       r_rem, n_rem;
    logic [mccps_pkg::NUM_W-1:0]       r_quo, n_quo;
    logic [mccps_pkg::STEP_W-1:0]      r_step, n_step;
    logic                              r_send, n_send;
    logic [6:0]                        r_value, n_value;

    logic                              w_cfg_wr;
    mccps_pkg::t_reg                   w_reg;
    logic [5:0]                        w_count;
    logic [5:0]                        w_cm1;
    logic [mccps_pkg::IDX_W-1:0]       w_den;
    logic [4:0]                        w_chan;
    logic [4:0]                        w_chan_m1;
    logic [7:0]                        w_status;
    logic [5:0]                        w_cur;
    logic                              w_match;
    logic [5:0]                        w_next;
    logic [5:0]                        w_next_m1;
    logic [mccps_pkg::IDX_W:0]         w_rs;
    logic                              w_ge;
    logic [6:0]                        w_m;
    logic [6:0]                        w_delta;
    logic                              w_better;
    logic [mccps_pkg::IDX_W-1:0]       w_best_upd;
    logic [mccps_pkg::IDX_W-1:0]       w_idx_inc;

    // ---------------------------------------------------------------------
    // Configuration port. Registers are indexed by paddr[3:2].
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = mccps_pkg::t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_count <= mccps_pkg::RST_PROFILE_COUNT;
            r_home_profile  <= mccps_pkg::RST_HOME_PROFILE;
            r_midi_channel  <= mccps_pkg::RST_MIDI_CHANNEL;
            r_cc_number     <= mccps_pkg::RST_CC_NUMBER;
        end else if (w_cfg_wr) begin
            case (w_reg)
                mccps_pkg::REG_PROFILE_COUNT: r_profile_count <= pwdata[5:0];
                mccps_pkg::REG_HOME_PROFILE:  r_home_profile  <= pwdata[5:0];
                mccps_pkg::REG_MIDI_CHANNEL:  r_midi_channel  <= pwdata[4:0];
                mccps_pkg::REG_CC_NUMBER:     r_cc_number     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            mccps_pkg::REG_PROFILE_COUNT: prdata = {26'b0, r_profile_count};
            mccps_pkg::REG_HOME_PROFILE:  prdata = {26'b0, r_home_profile};
            mccps_pkg::REG_MIDI_CHANNEL:  prdata = {27'b0, r_midi_channel};
            mccps_pkg::REG_CC_NUMBER:     prdata = {25'b0, r_cc_number};
            default:                      prdata = 32'b0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Derived settings. Configuration must only be changed while the block is idle;
    // the block does not enforce this. Kept to, these are steady for the life of an item.
    // ---------------------------------------------------------------------
    assign w_count   = mccps_pkg::clamp6(r_profile_count, 6'd1, 6'(mccps_pkg::MAX_PROFILES));
    assign w_cm1     = w_count - 6'd1;
    assign w_den     = w_cm1[mccps_pkg::IDX_W-1:0];
    assign w_chan    = 5'(mccps_pkg::clamp6({1'b0, r_midi_channel}, 6'd1, 6'd16));
    assign w_chan_m1 = w_chan - 5'd1;
    assign w_status  = mccps_pkg::CC_STATUS_BASE | {4'b0, w_chan_m1[3:0]};

    // The stored profile may lie beyond the count after a register write;
    // steps and home presses work from the clamped value.
    assign w_cur   = mccps_pkg::clamp6(r_profile, 6'd1, w_count);
    assign w_match = (i_status_in == w_status) && (i_data1_in == {1'b0, r_cc_number})
                     && !i_data2_in[7];

    always_comb begin
        case (mccps_pkg::t_op'(i_op))
            mccps_pkg::OP_STEP: begin
                if (i_step_up) w_next = (w_cur < w_count) ? w_cur + 6'd1 : w_cur;
                else           w_next = (w_cur > 6'd1) ? w_cur - 6'd1 : w_cur;
            end
            mccps_pkg::OP_HOME: w_next = mccps_pkg::clamp6(r_home_profile, 6'd1, w_count);
            default:            w_next = w_cur;
        endcase
    end
    assign w_next_m1 = w_next - 6'd1;

    // ---------------------------------------------------------------------
    // Shared divider: one restoring shift-subtract step per cycle. The
    // dividend shifts out of r_quo as quotient bits shift in.
    // ---------------------------------------------------------------------
    assign w_rs = {r_rem, r_quo[mccps_pkg::NUM_W-1]};
    assign w_ge = (w_rs >= {1'b0, w_den});

    // Quotient can reach 128 for the top profile; it saturates at 127.
    assign w_m = (r_quo > {5'b0, mccps_pkg::CC_VALUE_MAX}) ? mccps_pkg::CC_VALUE_MAX
                                                             : r_quo[6:0];

    // Nearest-profile tracking. Strict less-than keeps the first hit on ties.
    assign w_delta    = (w_m > r_val) ? (w_m - r_val) : (r_val - w_m);
    assign w_better   = ({1'b0, w_delta} < r_bestd);
    assign w_best_upd = w_better ? r_idx : r_best;
    assign w_idx_inc  = r_idx + mccps_pkg::IDX_W'(1);

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_profile = r_profile;
        n_search  = r_search;
        n_idx     = r_idx;
        n_best    = r_best;
        n_bestd   = r_bestd;
        n_val     = r_val;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_send    = r_send;
        n_value   = r_value;

        case (r_state)
            mccps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_send  = 1'b0;
                    n_value = 7'd0;
                    n_state = mccps_pkg::S_DONE;
                    n_rem   = '0;
                    n_step  = '0;
                    if (mccps_pkg::t_op'(i_op) == mccps_pkg::OP_MIDI_IN) begin
                        if (w_match) begin
                            if (w_count == 6'd1) begin
                                n_profile = 6'd1;
                            end else begin
                                // Start the nearest search at the first profile.
                                n_search = 1'b1;
                                n_idx    = '0;
                                n_best   = '0;
                                n_bestd  = 8'hFF;
                                n_val    = i_data2_in[6:0];
                                n_quo    = mccps_pkg::cc_dividend('0, w_den);
                                n_state  = mccps_pkg::S_DIV;
                            end
                        end
                    end else if ((w_next != w_cur) ||
                                 (mccps_pkg::t_op'(i_op) == mccps_pkg::OP_RESEND)) begin
                        n_profile = w_next;
                        n_send    = 1'b1;
                        if (w_count != 6'd1) begin
                            n_search = 1'b0;
                            n_quo    = mccps_pkg::cc_dividend(
                                           w_next_m1[mccps_pkg::IDX_W-1:0], w_den);
                            n_state  = mccps_pkg::S_DIV;
                        end
                    end
                end
            end
            mccps_pkg::S_DIV: begin
                if (w_ge) begin
                    n_rem = w_rs[mccps_pkg::IDX_W-1:0] - w_den;
                end else begin
                    n_rem = w_rs[mccps_pkg::IDX_W-1:0];
                end
                n_quo  = {r_quo[mccps_pkg::NUM_W-2:0], w_ge};
                n_step = r_step + mccps_pkg::STEP_W'(1);
                if (r_step == mccps_pkg::STEP_W'(mccps_pkg::DIV_STEPS - 1)) begin
                    n_state = mccps_pkg::S_EVAL;
                end
            end
            mccps_pkg::S_EVAL: begin
                if (r_search) begin
                    n_best  = w_best_upd;
                    n_bestd = w_better ? {1'b0, w_delta} : r_bestd;
                    if ({1'b0, r_idx} == w_cm1) begin
                        n_profile = {1'b0, w_best_upd} + 6'd1;
                        n_state   = mccps_pkg::S_DONE;
                    end else begin
                        n_idx   = w_idx_inc;
                        n_rem   = '0;
                        n_step  = '0;
                        n_quo   = mccps_pkg::cc_dividend(w_idx_inc, w_den);
                        n_state = mccps_pkg::S_DIV;
                    end
                end else begin
                    n_value = w_m;
                    n_state = mccps_pkg::S_DONE;
                end
            end
            mccps_pkg::S_DONE: begin
                if (i_out_ready) n_state = mccps_pkg::S_IDLE;
            end
            default: n_state = mccps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mccps_pkg::S_IDLE;
            r_profile <= mccps_pkg::RST_CUR_PROFILE;
            r_search  <= 1'b0;
            r_send    <= 1'b0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_profile <= n_profile;
            r_search  <= n_search;
            r_send    <= n_send;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_bestd <= n_bestd;
        r_val   <= n_val;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_value <= n_value;
    end

    // ---------------------------------------------------------------------
    // Outputs. Status and controller number are zero when nothing is sent.
    // ---------------------------------------------------------------------
    assign o_in_ready    = (r_state == mccps_pkg::S_IDLE);
    assign o_out_valid   = (r_state == mccps_pkg::S_DONE);
    assign o_send_valid  = r_send;
    assign o_status_out  = r_send ? w_status : 8'd0;
    assign o_cc_out      = r_send ? r_cc_number : 7'd0;
    assign o_value_out   = r_value;
    assign o_profile_out = r_profile;

`ifndef SYNTH
    // Input and result sides are never open at the same time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // Taking a result frees the block for the next item.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("block not ready after result transfer");

    // A sent CC always refers to a profile within the configured count.
    a_sent_profile_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_valid) |-> (o_profile_out >= 6'd1 && o_profile_out <= w_count))
        else $error("sent profile out of range");

    // The divider never runs past its last step.
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mccps_pkg::S_DIV) |->
        (r_step <= mccps_pkg::STEP_W'(mccps_pkg::DIV_STEPS - 1)))
        else $error("divider step count overrun");
`endif

endmodule
